// ===== sv/hcpw_pkg.sv =====
// Hilbert curve pixel walker: shared constants, types and helper functions.
// No dependencies; used by every module of the walker.
package hcpw_pkg;

    localparam int GRID_SPAN = 256;
    localparam int MAX_ORDER = 8;
    localparam int ORDER_W   = 4;
    localparam int COORD_W   = 8;
    localparam int SEG_W     = 2 * MAX_ORDER;
    localparam int SPAN_W    = COORD_W + 1;

    typedef struct packed {
        logic [ORDER_W-1:0] k;
        logic [SEG_W-1:0]   seg;
        logic [COORD_W-1:0] pix;
        logic               last;
    } t_seg_word;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } t_point;

    function automatic logic [ORDER_W-1:0] clamp_order(input logic [ORDER_W-1:0] k);
        logic [ORDER_W-1:0] r;
        r = k;
        if (k < ORDER_W'(1)) r = ORDER_W'(1);
        if (k > ORDER_W'(MAX_ORDER)) r = ORDER_W'(MAX_ORDER);
        return r;
    endfunction

    // spacing - 1, spacing = GRID_SPAN >> k
    function automatic logic [COORD_W-1:0] spacing_m1(input logic [ORDER_W-1:0] k);
        logic [SPAN_W-1:0] sp;
        sp = SPAN_W'(GRID_SPAN) >> k;
        return COORD_W'(sp - SPAN_W'(1));
    endfunction

    function automatic logic [COORD_W-1:0] half_spacing(input logic [ORDER_W-1:0] k);
        logic [SPAN_W-1:0] sp;
        sp = SPAN_W'(GRID_SPAN) >> k;
        return COORD_W'(sp >> 1);
    endfunction

    // index of the final segment: 4^k - 2
    function automatic logic [SEG_W-1:0] last_seg(input logic [ORDER_W-1:0] k);
        logic [SEG_W:0] n;
        n = (SEG_W+1)'(1) << {k, 1'b0};
        return SEG_W'(n - (SEG_W+1)'(2));
    endfunction

    // standard Hilbert index-to-xy, one quadrant level per step
    function automatic t_point d2xy(input logic [ORDER_W-1:0] k,
                                    input logic [SEG_W-1:0] d);
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] tmp;
        logic [COORD_W-1:0] mask;
        logic               rx;
        logic               ry;
        t_point             p;
        x = '0;
        y = '0;
        for (int i = 0; i < MAX_ORDER; i++) begin
            if (ORDER_W'(i) < k) begin
                rx   = d[2*i+1];
                ry   = d[2*i] ^ rx;
                mask = COORD_W'((SPAN_W'(1) << i) - SPAN_W'(1));
                if (!ry) begin
                    if (rx) begin
                        x = ~x & mask;
                        y = ~y & mask;
                    end
                    tmp = x;
                    x   = y;
                    y   = tmp;
                end
                x = x | (COORD_W'(rx) << i);
                y = y | (COORD_W'(ry) << i);
            end
        end
        p.x = x;
        p.y = y;
        return p;
    endfunction

endpackage

// ===== sv/hcpw_walker.sv =====
// Curve walker: order register, segment/pixel counters and the stage register
// that hands one segment word per emitted pixel to the plotter. Uses hcpw_pkg.
module hcpw_walker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic                        i_restart,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [hcpw_pkg::ORDER_W-1:0] i_cfg_curve_order,
    output logic                        o_seg_valid,
    output hcpw_pkg::t_seg_word         o_seg,
    input  logic                        i_seg_ready
);

    logic [hcpw_pkg::ORDER_W-1:0] r_cfg_order;
    logic [hcpw_pkg::ORDER_W-1:0] r_k, n_k;
    logic [hcpw_pkg::SEG_W-1:0]   r_seg, n_seg;
    logic [hcpw_pkg::COORD_W-1:0] r_pix, n_pix;
    logic                         r_fin, n_fin;
    logic                         r_s1_valid;
    hcpw_pkg::t_seg_word          r_s1;

    logic                         s1_ready;
    logic                         acc;
    logic                         emit;
    logic [hcpw_pkg::ORDER_W-1:0] cur_k;
    logic [hcpw_pkg::SEG_W-1:0]   cur_seg;
    logic [hcpw_pkg::COORD_W-1:0] cur_pix;
    logic                         pix_end;
    logic                         is_last;

    assign s1_ready    = !r_s1_valid || i_seg_ready;
    assign o_stall     = !s1_ready;
    assign acc         = i_valid && s1_ready;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        cur_k   = i_restart ? hcpw_pkg::clamp_order(r_cfg_order) : r_k;
        cur_seg = i_restart ? '0 : r_seg;
        cur_pix = i_restart ? '0 : r_pix;
        emit    = i_restart || !r_fin;
        pix_end = (cur_pix == hcpw_pkg::spacing_m1(cur_k));
        is_last = pix_end && (cur_seg == hcpw_pkg::last_seg(cur_k));
        n_k     = cur_k;
        n_seg   = pix_end ? cur_seg + hcpw_pkg::SEG_W'(1) : cur_seg;
        n_pix   = pix_end ? '0 : cur_pix + hcpw_pkg::COORD_W'(1);
        n_fin   = is_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_order <= hcpw_pkg::ORDER_W'(1);
            r_k         <= hcpw_pkg::ORDER_W'(1);
            r_seg       <= '0;
            r_pix       <= '0;
            r_fin       <= 1'b1;
            r_s1_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_cfg_order <= i_cfg_curve_order;
            end
            if (acc && emit) begin
                r_k   <= n_k;
                r_seg <= n_seg;
                r_pix <= n_pix;
                r_fin <= n_fin;
            end
            if (s1_ready) begin
                r_s1_valid <= acc && emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_ready) begin
            r_s1.k    <= cur_k;
            r_s1.seg  <= cur_seg;
            r_s1.pix  <= cur_pix;
            r_s1.last <= is_last;
        end
    end

    assign o_seg_valid = r_s1_valid;
    assign o_seg       = r_s1;

    a_order_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_k >= hcpw_pkg::ORDER_W'(1) && r_k <= hcpw_pkg::ORDER_W'(hcpw_pkg::MAX_ORDER))
        else $error("latched order out of range");

    a_pix_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_fin |-> r_pix <= hcpw_pkg::spacing_m1(r_k))
        else $error("pixel offset beyond segment");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && emit && is_last) |=> r_fin && r_s1_valid && r_s1.last)
        else $error("walker not finished after last pixel");

endmodule

// ===== sv/hcpw_plot.sv =====
// Plotter: maps a segment word to pixel coordinates via two Hilbert lookups
// and holds the result word in the output register. Uses hcpw_pkg.
module hcpw_plot (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_seg_valid,
    input  hcpw_pkg::t_seg_word          i_seg,
    output logic                         o_seg_ready,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [hcpw_pkg::COORD_W-1:0] o_pixel_x,
    output logic [hcpw_pkg::COORD_W-1:0] o_pixel_y,
    output logic                         o_last
);

    logic                         r_valid;
    logic [hcpw_pkg::COORD_W-1:0] r_x, n_x;
    logic [hcpw_pkg::COORD_W-1:0] r_y, n_y;
    logic                         r_last;

    hcpw_pkg::t_point             cur;
    hcpw_pkg::t_point             nxt;
    logic [hcpw_pkg::COORD_W-1:0] half;
    logic [hcpw_pkg::COORD_W-1:0] base_x;
    logic [hcpw_pkg::COORD_W-1:0] base_y;
    logic [3:0]                   sh;
    logic                         out_ready;

    assign out_ready   = !r_valid || !i_stall;
    assign o_seg_ready = out_ready;

    always_comb begin
        cur    = hcpw_pkg::d2xy(i_seg.k, i_seg.seg);
        nxt    = hcpw_pkg::d2xy(i_seg.k, i_seg.seg + hcpw_pkg::SEG_W'(1));
        half   = hcpw_pkg::half_spacing(i_seg.k);
        sh     = 4'(hcpw_pkg::COORD_W) - i_seg.k;
        base_x = (cur.x << sh) + half;
        base_y = (cur.y << sh) + half;
        n_x    = base_x;
        n_y    = base_y;
        if (nxt.x > cur.x) n_x = base_x + i_seg.pix;
        else if (nxt.x < cur.x) n_x = base_x - i_seg.pix;
        if (nxt.y > cur.y) n_y = base_y + i_seg.pix;
        else if (nxt.y < cur.y) n_y = base_y - i_seg.pix;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (out_ready) begin
            r_valid <= i_seg_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ready) begin
            r_x    <= n_x;
            r_y    <= n_y;
            r_last <= i_seg.last;
        end
    end

    assign o_valid   = r_valid;
    assign o_pixel_x = r_x;
    assign o_pixel_y = r_y;
    assign o_last    = r_last;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && i_stall) |=> r_valid && $stable(r_x) && $stable(r_y) && $stable(r_last))
        else $error("output word changed under stall");

endmodule

// ===== sv/hilbert_curve_pixel_walker_top.sv =====
// Hilbert curve pixel walker, top level: walker stage feeding the plotter.
// Path: an accepted word is registered in the walker stage register, then in the plotter output register.
// Throughput: one pixel word per cycle while i_valid is high and i_stall does not hold the output.
// Reset (sync, active low): order 1, walker idle until a restart word arrives.
// Depends on hcpw_pkg, hcpw_walker and hcpw_plot.
module hilbert_curve_pixel_walker_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic                         i_restart,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [hcpw_pkg::ORDER_W-1:0] i_cfg_curve_order,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [hcpw_pkg::COORD_W-1:0] o_pixel_x,
    output logic [hcpw_pkg::COORD_W-1:0] o_pixel_y,
    output logic                         o_last
);

    logic                seg_valid;
    logic                seg_ready;
    hcpw_pkg::t_seg_word seg;

    hcpw_walker u_walker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_restart         (i_restart),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_curve_order (i_cfg_curve_order),
        .o_seg_valid       (seg_valid),
        .o_seg             (seg),
        .i_seg_ready       (seg_ready)
    );

    hcpw_plot u_plot (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_seg_valid (seg_valid),
        .i_seg       (seg),
        .o_seg_ready (seg_ready),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_pixel_x   (o_pixel_x),
        .o_pixel_y   (o_pixel_y),
        .o_last      (o_last)
    );

endmodule
